>>> sv/differential_drive_limits_unit_defines.svh
// Assertion macros shared by the differential drive limits RTL.
`ifndef DIFFERENTIAL_DRIVE_LIMITS_UNIT_DEFINES_SVH
`define DIFFERENTIAL_DRIVE_LIMITS_UNIT_DEFINES_SVH

// Same-cycle implication, clocked on clk_i, off during reset.
`define DDL_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, clocked on clk_i, off during reset.
`define DDL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/ddl_pkg.sv
// Shared constants of the differential drive limits block.
package ddl_pkg;

  localparam int unsigned DEF_FRAC_BITS = 16;
  localparam int unsigned DEF_WORD_BITS = 32;

  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_TRACK_WIDTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WHEEL_LIMIT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ACCEL_UPPER = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ACCEL_LOWER = 2'd3;

endpackage

>>> sv/ddl_if.sv
// Valid/ready channel interfaces for path points and limit results.
interface ddl_in_if #(
  parameter int unsigned WORD_BITS = ddl_pkg::DEF_WORD_BITS
);
  logic                        valid;
  logic                        ready;
  logic signed [WORD_BITS-1:0] path_curvature;
  logic signed [WORD_BITS-1:0] chassis_velocity;

  modport source (output valid, output path_curvature, output chassis_velocity, input ready);
  modport sink   (input valid, input path_curvature, input chassis_velocity, output ready);
endinterface

interface ddl_out_if #(
  parameter int unsigned WORD_BITS = ddl_pkg::DEF_WORD_BITS
);
  logic                        valid;
  logic                        ready;
  logic signed [WORD_BITS-1:0] velocity_limit;
  logic signed [WORD_BITS-1:0] accel_min_out;
  logic signed [WORD_BITS-1:0] accel_max_out;

  modport source (output valid, output velocity_limit, output accel_min_out,
                  output accel_max_out, input ready);
  modport sink   (input valid, input velocity_limit, input accel_min_out,
                  input accel_max_out, output ready);
endinterface

>>> sv/ddl_div.sv
// Pipelined restoring divider: (num << (2F+1)) / den, one quotient bit per stage.
module ddl_div #(
  parameter int unsigned WORD_BITS = ddl_pkg::DEF_WORD_BITS,
  parameter int unsigned FRAC_BITS = ddl_pkg::DEF_FRAC_BITS
) (
  input  logic                  clk_i,
  input  logic [WORD_BITS:0]    en_i,
  input  logic [WORD_BITS-1:0]  num_i,
  input  logic [2*WORD_BITS+((2*WORD_BITS-1 > 2*FRAC_BITS+2) ? 0 : (2*FRAC_BITS+3-2*WORD_BITS))-1:0]
                                den_i,
  output logic [WORD_BITS-1:0]  quot_o,
  output logic                  ovf_o
);
  import ddl_pkg::*;

  localparam int unsigned TCW = 2 * WORD_BITS - 1;
  localparam int unsigned ONEW = 2 * FRAC_BITS + 2;
  localparam int unsigned DW = ((TCW > ONEW) ? TCW : ONEW) + 1;
  localparam int unsigned XW = DW + WORD_BITS;
  localparam int unsigned NS = WORD_BITS + 1;

  logic [XW-1:0]        rem_q [NS];
  logic [DW-1:0]        den_q [NS];
  logic [WORD_BITS-1:0] quo_q [NS];
  logic                 ovf_q [NS];

  logic [XW-1:0] rem0;
  assign rem0 = XW'(num_i) << (2 * FRAC_BITS + 1);

  // Quotient wider than WORD_BITS bits overflows; flag it up front.
  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      rem_q[0] <= rem0;
      den_q[0] <= den_i;
      quo_q[0] <= '0;
      ovf_q[0] <= (rem0 >= (XW'(den_i) << WORD_BITS));
    end
  end

  for (genvar j = 1; j < NS; j++) begin : g_bit
    localparam int unsigned BIT = WORD_BITS - j;
    logic [XW-1:0]        shifted;
    logic                 ge;
    logic [WORD_BITS-1:0] quo_d;

    always_comb begin
      shifted = XW'(den_q[j-1]) << BIT;
      ge      = rem_q[j-1] >= shifted;
      quo_d   = quo_q[j-1];
      quo_d[BIT] = ge;
    end

    always_ff @(posedge clk_i) begin
      if (en_i[j]) begin
        rem_q[j] <= ge ? (rem_q[j-1] - shifted) : rem_q[j-1];
        den_q[j] <= den_q[j-1];
        quo_q[j] <= quo_d;
        ovf_q[j] <= ovf_q[j-1];
      end
    end
  end

  assign quot_o = quo_q[NS-1];
  assign ovf_o  = ovf_q[NS-1];

endmodule

>>> sv/differential_drive_limits_unit.sv
// Top level of the differential drive velocity and acceleration limits block.
//
// For each path point (curvature, chassis velocity, signed Q16.16) the block returns the
// largest chassis velocity that keeps both wheels inside the wheel speed limit, plus the
// lowest and highest chassis acceleration for the turn. It accepts one point per clock
// while the output keeps accepting results and returns one result per point, in order.
// One stage forms magnitudes and the track-times-curvature product, one builds the three
// divisors, WORD_BITS + 1 stages run three restoring dividers side by side (one quotient
// bit per stage each, set by the divider chain), and one stage saturates and picks the
// special cases into the output register. Each stage advances when its successor is
// empty or moving, so bubbles collapse and an item can enter while a finished result
// still waits at the output. Configuration is written through the plain write port and
// must only change while the pipeline is empty.
`include "differential_drive_limits_unit_defines.svh"
module differential_drive_limits_unit #(
  parameter int unsigned WORD_BITS = ddl_pkg::DEF_WORD_BITS,
  parameter int unsigned FRAC_BITS = ddl_pkg::DEF_FRAC_BITS
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [ddl_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [WORD_BITS-1:0]           cfg_data_i,
  ddl_in_if.sink                         in_i,
  ddl_out_if.source                      out_o
);
  import ddl_pkg::*;

  localparam int unsigned W = WORD_BITS;
  localparam int unsigned TCW = 2 * W - 1;
  localparam int unsigned ONEW = 2 * FRAC_BITS + 2;
  localparam int unsigned DW = ((TCW > ONEW) ? TCW : ONEW) + 1;
  localparam int unsigned DNS = W + 1;
  localparam int unsigned LAST = DNS + 2;
  localparam int unsigned NS = LAST + 1;
  // |x| < 1e-5 in Q format, i.e. |x| * 100000 < 2^F
  localparam int unsigned TINY_LIM = ((2 ** FRAC_BITS) + 99999) / 100000;
  localparam logic [DW-1:0] ONE_X2 = DW'(1) << (2 * FRAC_BITS + 1);
  localparam logic signed [W-1:0] SMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] SMIN = {1'b1, {(W-1){1'b0}}};

  typedef struct packed {
    logic signed [W-1:0] v;
    logic [W-1:0]        vm;
    logic                v_neg;
    logic                v_pos;
    logic                tiny_v;
    logic                in_track;
    logic                min_neg;
    logic                min_dz;
    logic                min_aneg;
    logic                min_azero;
    logic                max_neg;
    logic                max_dz;
    logic                max_azero;
  } side_t;

  // Configuration registers
  logic [W-2:0]        tw_q, wsl_q, au_q;
  logic signed [W-1:0] al_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tw_q  <= (W-1)'(1) << FRAC_BITS;
      wsl_q <= (W-1)'(1) << FRAC_BITS;
      au_q  <= (W-1)'(1) << FRAC_BITS;
      al_q  <= -(W'(1) << FRAC_BITS);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_TRACK_WIDTH: tw_q  <= cfg_data_i[W-2:0];
        REG_WHEEL_LIMIT: wsl_q <= cfg_data_i[W-2:0];
        REG_ACCEL_UPPER: au_q  <= cfg_data_i[W-2:0];
        REG_ACCEL_LOWER: al_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Valid bits and per-stage advance
  logic [NS-1:0] v_q;
  logic [NS-1:0] en;

  always_comb begin
    en[LAST] = !v_q[LAST] || out_o.ready;
    for (int k = LAST - 1; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  assign in_i.ready = en[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) v_q[0] <= in_i.valid;
      for (int k = 1; k < NS; k++) begin
        if (en[k]) v_q[k] <= v_q[k-1];
      end
    end
  end

  // Stage 0: magnitudes and track * |curvature|
  logic [W-1:0]        cm_d, vm_d;
  logic signed [W-1:0] v0_q;
  logic [W-1:0]        cm0_q, vm0_q;
  logic [TCW-1:0]      tc0_q;

  assign cm_d = in_i.path_curvature[W-1] ? W'(-in_i.path_curvature) : W'(in_i.path_curvature);
  assign vm_d = in_i.chassis_velocity[W-1] ? W'(-in_i.chassis_velocity)
                                           : W'(in_i.chassis_velocity);

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      v0_q  <= in_i.chassis_velocity;
      cm0_q <= cm_d;
      vm0_q <= vm_d;
      tc0_q <= tw_q * cm_d;
    end
  end

  // Stage 1: divisors, numerators and sideband flags
  logic [DW-1:0] tc_w, dplus, dm_mag, dv;
  logic          in_track, dm_zero, tiny_c;
  side_t         side_d;
  logic [W-1:0]  nmin_d;
  logic [DW-1:0] dmin_d, dmax_d;

  always_comb begin
    tc_w     = DW'(tc0_q);
    dplus    = tc_w + ONE_X2;
    in_track = tc_w > ONE_X2;
    dm_zero  = tc_w == ONE_X2;
    dm_mag   = in_track ? (tc_w - ONE_X2) : (ONE_X2 - tc_w);
    tiny_c   = cm0_q < W'(TINY_LIM);
    dv       = tiny_c ? ONE_X2 : dplus;
    nmin_d   = al_q[W-1] ? W'(-al_q) : W'(al_q);

    side_d.v        = v0_q;
    side_d.vm       = vm0_q;
    side_d.v_neg    = v0_q[W-1];
    side_d.v_pos    = !v0_q[W-1] && (v0_q != '0);
    side_d.tiny_v   = vm0_q < W'(TINY_LIM);
    side_d.in_track = in_track;
    // minimum uses 1 - g only while moving forward
    dmin_d           = side_d.v_pos ? dm_mag : dplus;
    side_d.min_dz    = side_d.v_pos && dm_zero;
    side_d.min_aneg  = al_q[W-1];
    side_d.min_azero = al_q == '0;
    side_d.min_neg   = al_q[W-1] ^ (side_d.v_pos && in_track);
    // maximum uses 1 - g only while reversing
    dmax_d           = side_d.v_neg ? dm_mag : dplus;
    side_d.max_dz    = side_d.v_neg && dm_zero;
    side_d.max_azero = au_q == '0;
    side_d.max_neg   = side_d.v_neg && in_track;
  end

  side_t         side_q [1:LAST-1];
  logic [W-1:0]  nvel1_q, nmin1_q, nmax1_q;
  logic [DW-1:0] dvel1_q, dmin1_q, dmax1_q;

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      side_q[1] <= side_d;
      nvel1_q   <= W'(wsl_q);
      dvel1_q   <= dv;
      nmin1_q   <= nmin_d;
      dmin1_q   <= dmin_d;
      nmax1_q   <= W'(au_q);
      dmax1_q   <= dmax_d;
    end
  end

  // Sideband travels alongside the dividers
  for (genvar k = 2; k < LAST; k++) begin : g_side
    always_ff @(posedge clk_i) begin
      if (en[k]) side_q[k] <= side_q[k-1];
    end
  end

  // Dividers: stages 2 .. LAST-1
  logic [W-1:0] qvel, qmin, qmax;
  logic         ovel, omin, omax;

  ddl_div #(.WORD_BITS(WORD_BITS), .FRAC_BITS(FRAC_BITS)) u_div_vel (
    .clk_i (clk_i), .en_i (en[2 +: DNS]), .num_i (nvel1_q), .den_i (dvel1_q),
    .quot_o (qvel), .ovf_o (ovel)
  );

  ddl_div #(.WORD_BITS(WORD_BITS), .FRAC_BITS(FRAC_BITS)) u_div_min (
    .clk_i (clk_i), .en_i (en[2 +: DNS]), .num_i (nmin1_q), .den_i (dmin1_q),
    .quot_o (qmin), .ovf_o (omin)
  );

  ddl_div #(.WORD_BITS(WORD_BITS), .FRAC_BITS(FRAC_BITS)) u_div_max (
    .clk_i (clk_i), .en_i (en[2 +: DNS]), .num_i (nmax1_q), .den_i (dmax1_q),
    .quot_o (qmax), .ovf_o (omax)
  );

  // Saturate a quotient magnitude to the signed range
  function automatic logic signed [W-1:0] sat_quot(input logic [W-1:0] q, input logic ovf,
                                                   input logic neg);
    logic signed [W-1:0] r;
    if (!neg) begin
      r = (ovf || (q > W'(SMAX))) ? SMAX : q;
    end else begin
      r = (ovf || (q > W'(SMIN))) ? SMIN : -q;
    end
    return r;
  endfunction

  function automatic logic signed [W-1:0] sat_neg(input logic signed [W-1:0] x);
    return (x == SMIN) ? SMAX : -x;
  endfunction

  // Final stage: special cases and selection
  side_t               sf;
  logic signed [W-1:0] vpos, vel_d, amin_d, amax_d;

  always_comb begin
    sf   = side_q[LAST-1];
    vpos = sat_quot(qvel, 1'b0, 1'b0);
    if (sf.tiny_v) begin
      vel_d = '0;
    end else if (!ovel && (sf.vm > qvel)) begin
      // faster wheel over the limit: scale both down
      vel_d = sf.v_neg ? -vpos : vpos;
    end else begin
      vel_d = sf.v;
    end

    if (sf.min_dz) begin
      amin_d = sf.min_aneg ? SMIN : (sf.min_azero ? '0 : SMAX);
    end else begin
      amin_d = sat_quot(qmin, omin, sf.min_neg);
    end
    if (sf.max_dz) begin
      amax_d = sf.max_azero ? '0 : SMAX;
    end else begin
      amax_d = sat_quot(qmax, omax, sf.max_neg);
    end

    // turn center between the wheels: inner wheel limit flips
    if (sf.in_track && sf.v_pos) amin_d = sat_neg(amin_d);
    if (sf.in_track && sf.v_neg) amax_d = sat_neg(amax_d);
  end

  logic signed [W-1:0] vel_q, amin_q, amax_q;

  always_ff @(posedge clk_i) begin
    if (en[LAST]) begin
      vel_q  <= vel_d;
      amin_q <= amin_d;
      amax_q <= amax_d;
    end
  end

  assign out_o.valid          = v_q[LAST];
  assign out_o.velocity_limit = vel_q;
  assign out_o.accel_min_out  = amin_q;
  assign out_o.accel_max_out  = amax_q;

  `DDL_ASSERT_NEXT(a_accept_lands, in_i.valid && in_i.ready, v_q[0], "transfer lost at entry")
  `DDL_ASSERT_NOW(a_full_blocks, (&v_q) && !out_o.ready, !in_i.ready, "accepted into full pipe")
  `DDL_ASSERT_NEXT(a_stage_holds, v_q[1] && !en[1], v_q[1], "stalled stage dropped item")

endmodule
